[rtl/biq_pkg.sv]
`default_nettype none

package biq_pkg;

    // Fixed-point formats: samples Q1.23, coefficients Q4.20.
    localparam int SAMPLE_W    = 24;
    localparam int COEF_W      = 24;
    localparam int PROD_W      = SAMPLE_W + COEF_W;
    localparam int ACC_W       = PROD_W + 3;
    localparam int ROUND_SHIFT = 20;
    localparam int RND_W       = ACC_W - ROUND_SHIFT;
    localparam int NCOEF       = 5;

    // Request commands.
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_FILTER = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    // Coefficient slots, also the order in which the taps are accumulated.
    localparam logic [2:0] TAP_B0 = 3'd0;
    localparam logic [2:0] TAP_B1 = 3'd1;
    localparam logic [2:0] TAP_B2 = 3'd2;
    localparam logic [2:0] TAP_A1 = 3'd3;
    localparam logic [2:0] TAP_A2 = 3'd4;

    typedef struct packed {
        logic [1:0]                 cmd;
        logic [5:0]                 channel;
        logic [2:0]                 section;
        logic [2:0]                 coef_index;
        logic signed [COEF_W-1:0]   coef_value;
        logic signed [SAMPLE_W-1:0] sample;
    } in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] filtered;
        logic                       saturated;
    } out_t;

    // One history entry per channel and section.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x1;
        logic signed [SAMPLE_W-1:0] x2;
        logic signed [SAMPLE_W-1:0] y1;
        logic signed [SAMPLE_W-1:0] y2;
    } hist_t;

    localparam int HIST_W = $bits(hist_t);

    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic acc_first;
        logic acc_sub;
    } mac_ctrl_t;

endpackage

`default_nettype wire

[rtl/multichannel_biquad_cascade_unit.sv]
`default_nettype none

// Multichannel biquad cascade, direct form I, on one shared multiplier.
// Requests enter on s_valid/s_ready/s_payload and every request returns
// exactly one result on m_valid/m_ready/m_payload, in request order.
// A load request writes one coefficient into the shared table, a clear
// request zeroes one channel's histories, and a filter request runs one
// sample through all NUM_SECTIONS sections of its channel.
// Each section issues its five multiplies in S_MAC, drains the multiply
// and accumulate stages in S_DRAIN, and rounds, clips and writes the
// history back in S_ROUND; the section loop through the single
// multiplier sets how long a filter request takes. The result becomes
// valid in the same cycle in which the block is ready again.
// After reset the history memory is zeroed one entry per cycle with s_ready
// low. The coefficient table reads as zero until written. A result waits in
// the output register while the receiver stalls; the next request is still
// worked on and its result is held back until the register frees up.
module multichannel_biquad_cascade_unit #(
    parameter int CHANNELS     = 64,
    parameter int NUM_SECTIONS = 8
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire biq_pkg::in_t   s_payload,
    output logic                m_valid,
    input  wire logic           m_ready,
    output biq_pkg::out_t       m_payload
);

    localparam int COEF_DEPTH = NUM_SECTIONS * biq_pkg::NCOEF;
    localparam int COEF_AW    = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
    localparam int HIST_DEPTH = CHANNELS * NUM_SECTIONS;
    localparam int HIST_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int SEC_W      = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;

    localparam logic [SEC_W-1:0]   SEC_LAST  = SEC_W'(NUM_SECTIONS - 1);
    localparam logic [HIST_AW-1:0] HIST_LAST = HIST_AW'(HIST_DEPTH - 1);

    typedef enum logic [6:0] {
        S_INIT  = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_MAC   = 7'b0000100,
        S_DRAIN = 7'b0001000,
        S_ROUND = 7'b0010000,
        S_CLEAR = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t                               state_reg, state_next;
    logic [SEC_W-1:0]                     sec_reg, sec_next;
    logic [2:0]                           tap_reg, tap_next;
    logic [COEF_AW-1:0]                   coef_addr_reg, coef_addr_next;
    logic [HIST_AW-1:0]                   hist_addr_reg, hist_addr_next;
    logic signed [biq_pkg::SAMPLE_W-1:0]  x_reg, x_next;
    logic                                 sat_reg, sat_next;

    // Multiply pipeline tags: stage 1 multiplies, stage 2 accumulates.
    logic                                 p1_valid_reg, p2_valid_reg;
    logic [2:0]                           p1_tap_reg, p2_tap_reg;

    // One valid bit per coefficient entry; an unwritten entry reads as zero.
    logic [COEF_DEPTH-1:0]                coef_vld_reg;
    logic                                 coef_rdv_reg;

    logic                                 m_valid_reg;
    biq_pkg::out_t                        m_payload_reg;

    logic                                 issue;
    logic                                 load_out;
    logic                                 coef_we, coef_re;
    logic [COEF_AW-1:0]                   coef_waddr;
    logic [biq_pkg::COEF_W-1:0]           coef_rdata;
    logic                                 hist_we, hist_re;
    biq_pkg::hist_t                       hist_wdata;
    logic [biq_pkg::HIST_W-1:0]           hist_rdata;
    biq_pkg::hist_t                       hist_q;

    logic                                 ch_ok;
    logic                                 slot_ok;
    logic [HIST_AW-1:0]                   hist_base;

    biq_pkg::mac_ctrl_t                   mac_ctrl;
    logic signed [biq_pkg::COEF_W-1:0]    mac_coef;
    logic signed [biq_pkg::SAMPLE_W-1:0]  mac_operand;
    logic signed [biq_pkg::SAMPLE_W-1:0]  mac_y;
    logic                                 mac_clip;

    assign hist_q    = biq_pkg::hist_t'(hist_rdata);
    assign ch_ok     = 32'(s_payload.channel) < CHANNELS;
    assign slot_ok   = (32'(s_payload.section) < NUM_SECTIONS) &&
                       (32'(s_payload.coef_index) < biq_pkg::NCOEF);
    assign hist_base = HIST_AW'(32'(s_payload.channel) * NUM_SECTIONS);
    assign coef_waddr = COEF_AW'(32'(s_payload.section) * biq_pkg::NCOEF +
                                 32'(s_payload.coef_index));

    assign s_ready = (state_reg == S_IDLE);

    // Sequencer.
    always_comb begin
        state_next     = state_reg;
        sec_next       = sec_reg;
        tap_next       = tap_reg;
        coef_addr_next = coef_addr_reg;
        hist_addr_next = hist_addr_reg;
        x_next         = x_reg;
        sat_next       = sat_reg;
        issue          = 1'b0;
        load_out       = 1'b0;
        coef_we        = 1'b0;
        coef_re        = 1'b0;
        hist_we        = 1'b0;
        hist_re        = 1'b0;
        hist_wdata     = '0;

        unique case (state_reg)
            S_INIT: begin
                hist_we = 1'b1;
                if (hist_addr_reg == HIST_LAST) begin
                    hist_addr_next = '0;
                    state_next     = S_IDLE;
                end else begin
                    hist_addr_next = hist_addr_reg + HIST_AW'(1);
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    x_next     = '0;
                    sat_next   = 1'b0;
                    state_next = S_DONE;
                    case (s_payload.cmd)
                        biq_pkg::CMD_LOAD: begin
                            coef_we = slot_ok;
                        end
                        biq_pkg::CMD_FILTER: begin
                            if (ch_ok) begin
                                x_next         = s_payload.sample;
                                sec_next       = '0;
                                tap_next       = biq_pkg::TAP_B0;
                                coef_addr_next = '0;
                                hist_addr_next = hist_base;
                                state_next     = S_MAC;
                            end
                        end
                        biq_pkg::CMD_CLEAR: begin
                            if (ch_ok) begin
                                sec_next       = '0;
                                hist_addr_next = hist_base;
                                state_next     = S_CLEAR;
                            end
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_MAC: begin
                issue          = 1'b1;
                coef_re        = 1'b1;
                hist_re        = (tap_reg == biq_pkg::TAP_B0);
                coef_addr_next = coef_addr_reg + COEF_AW'(1);
                if (tap_reg == biq_pkg::TAP_A2) begin
                    tap_next   = biq_pkg::TAP_B0;
                    state_next = S_DRAIN;
                end else begin
                    tap_next = tap_reg + 3'd1;
                end
            end
            S_DRAIN: begin
                if (p2_valid_reg && (p2_tap_reg == biq_pkg::TAP_A2)) begin
                    state_next = S_ROUND;
                end
            end
            S_ROUND: begin
                hist_we       = 1'b1;
                hist_wdata.x1 = x_reg;
                hist_wdata.x2 = hist_q.x1;
                hist_wdata.y1 = mac_y;
                hist_wdata.y2 = hist_q.y1;
                x_next        = mac_y;
                sat_next      = sat_reg | mac_clip;
                if (sec_reg == SEC_LAST) begin
                    state_next = S_DONE;
                end else begin
                    sec_next       = sec_reg + SEC_W'(1);
                    hist_addr_next = hist_addr_reg + HIST_AW'(1);
                    state_next     = S_MAC;
                end
            end
            S_CLEAR: begin
                hist_we = 1'b1;
                if (sec_reg == SEC_LAST) begin
                    state_next = S_DONE;
                end else begin
                    sec_next       = sec_reg + SEC_W'(1);
                    hist_addr_next = hist_addr_reg + HIST_AW'(1);
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_INIT;
            hist_addr_reg <= '0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            coef_vld_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            hist_addr_reg <= hist_addr_next;
            p1_valid_reg  <= issue;
            p2_valid_reg  <= p1_valid_reg;
            if (coef_we) begin
                coef_vld_reg[coef_waddr] <= 1'b1;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        sec_reg       <= sec_next;
        tap_reg       <= tap_next;
        coef_addr_reg <= coef_addr_next;
        x_reg         <= x_next;
        sat_reg       <= sat_next;
        p1_tap_reg    <= tap_reg;
        p2_tap_reg    <= p1_tap_reg;
        if (coef_re) begin
            coef_rdv_reg <= coef_vld_reg[coef_addr_reg];
        end
        if (load_out) begin
            m_payload_reg.filtered  <= x_reg;
            m_payload_reg.saturated <= sat_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // Operands of the multiply stage; feedback taps are subtracted.
    always_comb begin
        case (p1_tap_reg)
            biq_pkg::TAP_B0: mac_operand = x_reg;
            biq_pkg::TAP_B1: mac_operand = hist_q.x1;
            biq_pkg::TAP_B2: mac_operand = hist_q.x2;
            biq_pkg::TAP_A1: mac_operand = hist_q.y1;
            biq_pkg::TAP_A2: mac_operand = hist_q.y2;
            default:         mac_operand = '0;
        endcase
    end

    assign mac_coef           = coef_rdv_reg ? coef_rdata : '0;
    assign mac_ctrl.mul_en    = p1_valid_reg;
    assign mac_ctrl.acc_en    = p2_valid_reg;
    assign mac_ctrl.acc_first = (p2_tap_reg == biq_pkg::TAP_B0);
    assign mac_ctrl.acc_sub   = (p2_tap_reg == biq_pkg::TAP_A1) ||
                                (p2_tap_reg == biq_pkg::TAP_A2);

    biq_ram #(
        .WIDTH (biq_pkg::COEF_W),
        .DEPTH (COEF_DEPTH)
    ) u_coef_ram (
        .aclk    (aclk),
        .wr_en   (coef_we),
        .wr_addr (coef_waddr),
        .wr_data (s_payload.coef_value),
        .rd_en   (coef_re),
        .rd_addr (coef_addr_reg),
        .rd_data (coef_rdata)
    );

    biq_ram #(
        .WIDTH (biq_pkg::HIST_W),
        .DEPTH (HIST_DEPTH)
    ) u_hist_ram (
        .aclk    (aclk),
        .wr_en   (hist_we),
        .wr_addr (hist_addr_reg),
        .wr_data (hist_wdata),
        .rd_en   (hist_re),
        .rd_addr (hist_addr_reg),
        .rd_data (hist_rdata)
    );

    biq_mac u_mac (
        .aclk    (aclk),
        .ctrl    (mac_ctrl),
        .coef    (mac_coef),
        .operand (mac_operand),
        .y       (mac_y),
        .clip    (mac_clip)
    );

`ifndef NO_ASSERTIONS
    // An accepted in-range filter request starts the multiply sequence.
    a_filter_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_payload.cmd == biq_pkg::CMD_FILTER) && ch_ok)
        |=> (state_reg == S_MAC))
        else $error("filter request did not start the section sequence");

    // The pipeline is empty when a section is rounded and written back.
    a_round_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ROUND) |-> (!p1_valid_reg && !p2_valid_reg))
        else $error("rounding while multiply pipeline still busy");

    // The last tap reaching the accumulator ends the drain.
    a_drain_end: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_DRAIN) && p2_valid_reg && (p2_tap_reg == biq_pkg::TAP_A2))
        |=> (state_reg == S_ROUND))
        else $error("drain did not end after the last tap");

    // A pending result is never overwritten.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !load_out)
        else $error("result register overwritten while stalled");
`endif

endmodule

`default_nettype wire

[rtl/biq_ram.sv]
`default_nettype none

module biq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 40
) (
    input  wire logic                                      aclk,
    input  wire logic                                      wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                          wr_data,
    input  wire logic                                      rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // The read data holds its value until the next read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[rtl/biq_mac.sv]
`default_nettype none

module biq_mac (
    input  wire logic                                   aclk,
    input  wire biq_pkg::mac_ctrl_t                     ctrl,
    input  wire logic signed [biq_pkg::COEF_W-1:0]      coef,
    input  wire logic signed [biq_pkg::SAMPLE_W-1:0]    operand,
    output logic signed [biq_pkg::SAMPLE_W-1:0]         y,
    output logic                                        clip
);

    localparam logic signed [biq_pkg::RND_W-1:0] SAT_MAX =
        biq_pkg::RND_W'((2 ** (biq_pkg::SAMPLE_W - 1)) - 1);
    localparam logic signed [biq_pkg::RND_W-1:0] SAT_MIN =
        -biq_pkg::RND_W'(2 ** (biq_pkg::SAMPLE_W - 1));
    localparam logic signed [biq_pkg::ACC_W-1:0] HALF_LSB =
        biq_pkg::ACC_W'(2 ** (biq_pkg::ROUND_SHIFT - 1));

    logic signed [biq_pkg::PROD_W-1:0] prod_reg;
    logic signed [biq_pkg::ACC_W-1:0]  acc_reg;
    logic signed [biq_pkg::ACC_W-1:0]  prod_ext;
    logic signed [biq_pkg::ACC_W-1:0]  term;
    logic signed [biq_pkg::ACC_W-1:0]  biased;
    logic signed [biq_pkg::RND_W-1:0]  rounded;

    assign prod_ext = biq_pkg::ACC_W'(prod_reg);
    assign term     = ctrl.acc_sub ? -prod_ext : prod_ext;

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= coef * operand;
        end
        if (ctrl.acc_en) begin
            acc_reg <= ctrl.acc_first ? term : acc_reg + term;
        end
    end

    // Round half up to Q1.23, then clip to the sample range.
    assign biased  = acc_reg + HALF_LSB;
    assign rounded = biq_pkg::RND_W'(biased >>> biq_pkg::ROUND_SHIFT);

    always_comb begin
        clip = 1'b0;
        y    = biq_pkg::SAMPLE_W'(rounded);
        if (rounded > SAT_MAX) begin
            y    = biq_pkg::SAMPLE_W'(SAT_MAX);
            clip = 1'b1;
        end else if (rounded < SAT_MIN) begin
            y    = biq_pkg::SAMPLE_W'(SAT_MIN);
            clip = 1'b1;
        end
    end

endmodule

`default_nettype wire
